>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the XORWOW generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XWG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/xwg_pkg.sv
// Types and constants of the four-lane XORWOW generator.
package xwg_pkg;

  localparam int unsigned MaxLanes = 4;
  localparam int unsigned Slots = 5;
  localparam int unsigned WordW = 32;
  localparam int unsigned SlotW = 3;
  localparam int unsigned LaneW = 2;
  localparam logic [WordW-1:0] WeylStep = 32'd362437;
  localparam logic [SlotW-1:0] SlotLimit = 3'd5;

  typedef enum logic {
    ActLoad     = 1'b0,
    ActGenerate = 1'b1
  } action_e;

  typedef struct packed {
    logic             load_en;
    logic             gen_en;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] value;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/xorwow_four_lane_generator_core.sv
// Top level of the four-lane XORWOW generator with stream input and output.
//
// The slave channel carries one transaction per request. tuser selects the
// kind: a load writes one seed word into one lane and history slot and clears
// the shared Weyl counter; a generate advances the counter and every active
// lane by one XORWOW step. A load produces no output; a load naming a slot
// above four or an inactive lane is dropped without effect.
// Each generate produces one master transaction with four 32-bit words, lane
// zero in the lowest bits; words of lanes at or above LANES read as zero.
// The step is computed from the lane registers in the cycle the request is
// taken and the result is registered, so the result appears in the cycle after
// acceptance; while tready stays high, one request can be taken every cycle.
// The output register is a single stage: while the receiver holds tready low
// with a result pending, the input stalls too; a new request is taken in the
// same cycle the pending result leaves.
// Reset clears all history words, the counter and the output valid flag.
`include "assert_macros.svh"

module xorwow_four_lane_generator_core #(
  parameter int unsigned LANES = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // seed_lane [1:0], seed_slot [4:2], seed_value [36:5], zero [39:37]
  input  logic [39:0]   s_axis_tdata_i,
  // action [0]
  input  logic          s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // rand_lane0 [31:0], rand_lane1 [63:32], rand_lane2 [95:64], rand_lane3 [127:96]
  output logic [127:0]  m_axis_tdata_o
);

  localparam int unsigned OutW = xwg_pkg::MaxLanes * xwg_pkg::WordW;
  localparam logic [2:0] LanesW = 3'(LANES);
  localparam logic [OutW-1:0] ActiveMask =
    {OutW{1'b1}} >> (xwg_pkg::WordW * (xwg_pkg::MaxLanes - LANES));

  logic [xwg_pkg::LaneW-1:0] seed_lane;
  logic [xwg_pkg::SlotW-1:0] seed_slot;
  logic [xwg_pkg::WordW-1:0] seed_value;
  xwg_pkg::action_e          action;
  logic                      in_acc;
  logic                      gen_acc;
  logic                      load_ok;
  logic [xwg_pkg::WordW-1:0] weyl_q;
  logic [xwg_pkg::WordW-1:0] weyl_d;
  logic [xwg_pkg::WordW-1:0] weyl_next;
  logic [OutW-1:0]           result;
  logic [OutW-1:0]           out_data_q;
  logic                      out_valid_q;
  logic                      out_valid_d;

  assign seed_lane  = s_axis_tdata_i[1:0];
  assign seed_slot  = s_axis_tdata_i[4:2];
  assign seed_value = s_axis_tdata_i[36:5];
  assign action     = xwg_pkg::action_e'(s_axis_tuser_i);

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign gen_acc = in_acc && (action == xwg_pkg::ActGenerate);
  assign load_ok = in_acc && (action == xwg_pkg::ActLoad) &&
                   (seed_slot < xwg_pkg::SlotLimit) && ({1'b0, seed_lane} < LanesW);

  assign weyl_next = weyl_q + xwg_pkg::WeylStep;

  always_comb begin
    weyl_d = weyl_q;
    if (load_ok) begin
      weyl_d = '0;
    end else if (gen_acc) begin
      weyl_d = weyl_next;
    end
  end

  for (genvar k = 0; k < xwg_pkg::MaxLanes; k++) begin : g_lane
    if (k < LANES) begin : g_active
      xwg_pkg::lane_ctrl_t ctrl;

      assign ctrl.load_en = load_ok && (seed_lane == xwg_pkg::LaneW'(k));
      assign ctrl.gen_en  = gen_acc;
      assign ctrl.slot    = seed_slot;
      assign ctrl.value   = seed_value;

      xwg_lane u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .weyl_next_i (weyl_next),
        .rand_o      (result[k*xwg_pkg::WordW +: xwg_pkg::WordW])
      );
    end else begin : g_idle
      assign result[k*xwg_pkg::WordW +: xwg_pkg::WordW] = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (gen_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weyl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      weyl_q      <= weyl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_acc) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `XWG_ASSERT_NEXT(a_load_clears_weyl, load_ok, weyl_q == '0, "valid load did not clear counter")
  `XWG_ASSERT_NEXT(a_gen_steps_weyl, gen_acc, weyl_q == $past(weyl_next), "counter did not step")
  `XWG_ASSERT_NEXT(a_gen_gives_result, gen_acc, m_axis_tvalid_o, "generate gave no result")
  `XWG_ASSERT_NEXT(a_no_spurious_result, !out_valid_q && !gen_acc, !m_axis_tvalid_o, "result appeared without a generate")
  `XWG_ASSERT_NOW(a_idle_lanes_zero, m_axis_tvalid_o, (m_axis_tdata_o & ~ActiveMask) == '0, "inactive lane word not zero")

endmodule

>>> hw/rtl/xwg_lane.sv
// One XORWOW lane: five history words and the generate step.
module xwg_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xwg_pkg::lane_ctrl_t           ctrl_i,
  input  logic [xwg_pkg::WordW-1:0]     weyl_next_i,
  output logic [xwg_pkg::WordW-1:0]     rand_o
);

  logic [xwg_pkg::WordW-1:0] history_q [xwg_pkg::Slots];
  logic [xwg_pkg::WordW-1:0] history_d [xwg_pkg::Slots];
  logic [xwg_pkg::WordW-1:0] oldest;
  logic [xwg_pkg::WordW-1:0] newest;
  logic [xwg_pkg::WordW-1:0] mix_a;
  logic [xwg_pkg::WordW-1:0] mix_b;
  logic [xwg_pkg::WordW-1:0] step_word;

  assign oldest    = history_q[xwg_pkg::Slots-1];
  assign newest    = history_q[0];
  assign mix_a     = oldest ^ (oldest >> 2);
  assign mix_b     = mix_a ^ (mix_a << 1);
  assign step_word = mix_b ^ newest ^ (newest << 4);
  assign rand_o    = step_word + weyl_next_i;

  always_comb begin
    for (int i = 0; i < xwg_pkg::Slots; i++) begin
      history_d[i] = history_q[i];
      if (ctrl_i.load_en && (ctrl_i.slot == xwg_pkg::SlotW'(i))) begin
        history_d[i] = ctrl_i.value;
      end
    end
    if (ctrl_i.gen_en) begin
      history_d[0] = step_word;
      for (int i = 1; i < xwg_pkg::Slots; i++) begin
        history_d[i] = history_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xwg_pkg::Slots; i++) begin
        history_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < xwg_pkg::Slots; i++) begin
        history_q[i] <= history_d[i];
      end
    end
  end

endmodule
